[rtl/stpu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Section time profiler package
// Field widths, operation and result codes, and constants that are shared by
// the interfaces, the tick store and the sequencer.
// ----------------------------------------------------------------------------
package stpu_pkg;

    // Default number of profiled sections.
    localparam int SECTIONS_DEF = 12;

    // Field widths of the input and result items.
    localparam int OP_W    = 2;
    localparam int SEC_W   = 4;
    localparam int TIME_W  = 32;
    localparam int VAL_W   = 31;
    localparam int KIND_W  = 2;

    // Widths of the accumulated state.
    localparam int FRAME_W = 16;
    localparam int TICK_W  = 48;

    // Microseconds in one second, and the width of that constant.
    localparam int                US_W     = 20;
    localparam logic [US_W-1:0]   US_PER_S = 20'd1000000;

    // Product of a tick count and the microsecond constant.
    localparam int ACC_W = TICK_W + US_W;

    // Tick rate after reset.
    localparam logic [TIME_W-1:0] TPS_RESET = 32'd46875000;

    // Operation codes of an input item.
    typedef enum logic [OP_W-1:0] {
        OP_MARK   = 2'd0,
        OP_FRAME  = 2'd1,
        OP_ENABLE = 2'd2
    } t_op;

    // Kinds of result item.
    typedef enum logic [KIND_W-1:0] {
        KIND_SECTION = 2'd0,
        KIND_FRAMES  = 2'd1,
        KIND_WORST   = 2'd2
    } t_kind;

endpackage : stpu_pkg
`default_nettype wire

[rtl/stpu_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Section time profiler channels
// Event channel into the profiler and report channel out of it, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface stpu_in_if;
    import stpu_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SEC_W-1:0]  section;
    logic [TIME_W-1:0] now;
    logic              enable_on;

    modport source (output valid, output operation, output section, output now,
                    output enable_on, input ready);
    modport sink   (input valid, input operation, input section, input now,
                    input enable_on, output ready);
endinterface : stpu_in_if

interface stpu_out_if;
    import stpu_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SEC_W-1:0]  section_res;
    logic [VAL_W-1:0]  value_us;
    logic              last;

    modport source (output valid, output kind, output section_res, output value_us,
                    output last, input ready);
    modport sink   (input valid, input kind, input section_res, input value_us,
                    input last, output ready);
endinterface : stpu_out_if
`default_nettype wire

[rtl/section_time_profiler_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Section time profiler
// Charges timestamped intervals to sections and, once per second of ticks,
// reports the average microseconds per frame of every section, the frame
// count and the worst frame length.
// ----------------------------------------------------------------------------
//  Channel      Direction  Handshake      Payload
//  i_item       in         valid/ready    operation, section, now, enable_on
//  o_res        out        valid/ready    kind, section_res, value_us, last
//  i_cfg_*      in         write enable   tick rate
//
//  An enable item or an ignored item is handled in the idle state; a
//  mark or a frame also passes through the charge state. In a report,
//  the section rows and the worst row go through the 20-step
//  shift-and-add scaling and the 31-step restoring division, both on the
//  one shared adder. The input is ready only while the sequencer is idle.
//  Results leave through an output register; a stalled output holds the
//  report at that row. Reset is synchronous and clears all profiling state.
// ----------------------------------------------------------------------------
module section_time_profiler_unit #(
    parameter int SECTIONS = stpu_pkg::SECTIONS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [stpu_pkg::TIME_W-1:0] i_cfg_wdata,
    stpu_in_if.sink                     i_item,
    stpu_out_if.source                  o_res
);
    import stpu_pkg::*;

    localparam int AW    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int ROW_W = $clog2(SECTIONS + 2);
    localparam int BIT_W = $clog2(US_W);
    localparam int CNT_W = $clog2(VAL_W);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHARGE,
        S_DMUL,
        S_ROW,
        S_LOAD,
        S_MUL,
        S_DIV0,
        S_DIV,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [TIME_W-1:0]   r_tps;
    logic                r_on;
    logic [AW-1:0]       r_running;
    logic [TIME_W-1:0]   r_last_mark;
    logic [TIME_W-1:0]   r_frame_start;
    logic [TIME_W-1:0]   r_window_start;
    logic [TIME_W-1:0]   r_worst;
    logic [FRAME_W-1:0]  r_frames;
    logic [TIME_W-1:0]   r_now;
    logic [AW-1:0]       r_next;
    logic                r_is_frame;
    logic [ROW_W-1:0]    r_row;
    logic [TICK_W-1:0]   r_div;
    logic [TICK_W-1:0]   r_tval;
    logic [ACC_W-1:0]    r_acc;
    logic [TICK_W-1:0]   r_rem;
    logic [VAL_W-1:0]    r_low;
    logic [VAL_W-1:0]    r_val;
    logic [BIT_W-1:0]    r_bit;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    t_kind               r_out_kind;
    logic [SEC_W-1:0]    r_out_sec;
    logic [VAL_W-1:0]    r_out_val;
    logic                r_out_last;

    logic [TIME_W-1:0]   w_rate;
    logic                w_accept;
    logic [TIME_W-1:0]   w_delta;
    logic [TIME_W-1:0]   w_flen;
    logic [TIME_W-1:0]   w_win;
    logic [TICK_W-1:0]   w_prod;
    logic                w_out_free;
    logic [AW-1:0]       w_mark_sec;
    logic                w_row_sec;
    logic                w_row_cnt;
    logic                w_row_last;
    logic [ACC_W-1:0]    w_opa;
    logic [ACC_W-1:0]    w_opb;
    logic                w_sub;
    logic [ACC_W-1:0]    w_sum;
    logic                w_carry;
    logic                w_clr;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [TICK_W-1:0]   w_wdata;
    logic [AW-1:0]       w_raddr;
    logic [TICK_W-1:0]   w_rdata;

    // A zero tick rate counts as one tick per second.
    assign w_rate   = (r_tps == '0) ? TIME_W'(1) : r_tps;
    assign w_accept = i_item.valid && i_item.ready;

    // Tick distances, all modulo 2^32.
    assign w_delta = r_now - r_last_mark;
    assign w_flen  = r_now - r_frame_start;
    assign w_win   = r_now - r_window_start;

    // Divisor for the section rows: ticks per second times frames.
    assign w_prod = w_rate * r_frames;

    assign w_out_free = !r_out_valid || o_res.ready;

    // A mark naming a section out of range runs section 0 instead.
    assign w_mark_sec = (32'(i_item.section) < SECTIONS) ? AW'(i_item.section) : '0;

    // Row decode of the report: sections first, then frame count, then worst.
    assign w_row_sec  = 32'(r_row) < SECTIONS;
    assign w_row_cnt  = 32'(r_row) == SECTIONS;
    assign w_row_last = 32'(r_row) == SECTIONS + 1;

    // Operand selection for the shared adder.
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        w_sub = 1'b0;
        case (r_state)
            S_CHARGE: begin
                w_opa = ACC_W'(w_rdata);
                w_opb = ACC_W'(w_delta);
            end
            S_MUL: begin
                w_opa = {r_acc[ACC_W-2:0], 1'b0};
                w_opb = US_PER_S[r_bit] ? ACC_W'(r_tval) : '0;
            end
            S_DIV0: begin
                w_opa = ACC_W'(r_acc[ACC_W-1:VAL_W]);
                w_opb = ACC_W'(r_div);
                w_sub = 1'b1;
            end
            S_DIV: begin
                w_opa = ACC_W'({r_rem, r_low[VAL_W-1]});
                w_opb = ACC_W'(r_div);
                w_sub = 1'b1;
            end
            default: begin
                w_sub = 1'b0;
            end
        endcase
    end

    stpu_alu u_alu (
        .i_opa   (w_opa),
        .i_opb   (w_opb),
        .i_sub   (w_sub),
        .o_sum   (w_sum),
        .o_carry (w_carry)
    );

    // Tick store control: charge writes the saturated total, a report row
    // zeroes the entry it has just read.
    assign w_clr   = w_accept && (i_item.operation == OP_ENABLE);
    assign w_we    = (r_state == S_CHARGE) || (r_state == S_LOAD);
    assign w_waddr = (r_state == S_LOAD) ? r_row[AW-1:0] : r_running;
    assign w_wdata = (r_state == S_LOAD) ? '0 :
                     (w_sum[TICK_W] ? '1 : w_sum[TICK_W-1:0]);
    assign w_raddr = (r_state == S_ROW) ? r_row[AW-1:0] : r_running;

    stpu_tick_mem #(
        .DEPTH (SECTIONS),
        .AW    (AW)
    ) u_tick_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_clr),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sequencer with its datapath and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_tps          <= TPS_RESET;
            r_on           <= 1'b0;
            r_running      <= '0;
            r_last_mark    <= '0;
            r_frame_start  <= '0;
            r_window_start <= '0;
            r_worst        <= '0;
            r_frames       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
            // The output register empties once its item is taken; in the
            // emit state the next row refills it instead.
            if (r_out_valid && o_res.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_item.operation == OP_ENABLE) begin
                            r_on           <= i_item.enable_on;
                            r_running      <= '0;
                            r_last_mark    <= i_item.now;
                            r_frame_start  <= i_item.now;
                            r_window_start <= i_item.now;
                            r_frames       <= '0;
                            r_worst        <= '0;
                        end else if (r_on && (i_item.operation == OP_MARK ||
                                              i_item.operation == OP_FRAME)) begin
                            r_now      <= i_item.now;
                            r_is_frame <= (i_item.operation == OP_FRAME);
                            r_next     <= (i_item.operation == OP_FRAME) ? '0 : w_mark_sec;
                            r_state    <= S_CHARGE;
                        end
                    end
                end

                // Charge the elapsed ticks; a frame also closes the frame and
                // checks whether the window has run a full second.
                S_CHARGE: begin
                    r_last_mark <= r_now;
                    r_running   <= r_next;
                    if (!r_is_frame) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_frame_start <= r_now;
                        if (w_flen > r_worst) begin
                            r_worst <= w_flen;
                        end
                        if (r_frames != '1) begin
                            r_frames <= r_frames + FRAME_W'(1);
                        end
                        if (w_win >= w_rate) begin
                            r_window_start <= r_now;
                            r_row          <= '0;
                            r_state        <= S_DMUL;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                S_DMUL: begin
                    r_div   <= w_prod;
                    r_state <= S_ROW;
                end

                // Start one report row.
                S_ROW: begin
                    if (w_row_sec) begin
                        r_state <= S_LOAD;
                    end else if (w_row_cnt) begin
                        r_val   <= VAL_W'(r_frames);
                        r_state <= S_EMIT;
                    end else begin
                        r_tval  <= TICK_W'(r_worst);
                        r_div   <= TICK_W'(w_rate);
                        r_acc   <= '0;
                        r_bit   <= BIT_W'(US_W - 1);
                        r_state <= S_MUL;
                    end
                end

                S_LOAD: begin
                    r_tval  <= w_rdata;
                    r_acc   <= '0;
                    r_bit   <= BIT_W'(US_W - 1);
                    r_state <= S_MUL;
                end

                // Ticks times one million, one constant bit per cycle.
                S_MUL: begin
                    r_acc <= w_sum;
                    if (r_bit == '0) begin
                        r_state <= S_DIV0;
                    end else begin
                        r_bit <= r_bit - BIT_W'(1);
                    end
                end

                // A quotient of 2^31 or more saturates at once.
                S_DIV0: begin
                    if (w_carry) begin
                        r_val   <= '1;
                        r_state <= S_EMIT;
                    end else begin
                        r_rem   <= TICK_W'(r_acc[ACC_W-1:VAL_W]);
                        r_low   <= r_acc[VAL_W-1:0];
                        r_val   <= '0;
                        r_cnt   <= CNT_W'(VAL_W - 1);
                        r_state <= S_DIV;
                    end
                end

                // Restoring division, one quotient bit per cycle.
                S_DIV: begin
                    r_val <= {r_val[VAL_W-2:0], w_carry};
                    r_rem <= w_carry ? w_sum[TICK_W-1:0] : {r_rem[TICK_W-2:0], r_low[VAL_W-1]};
                    r_low <= {r_low[VAL_W-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end

                // Hand the row to the output register when it is free.
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= w_row_sec ? KIND_SECTION :
                                       (w_row_cnt ? KIND_FRAMES : KIND_WORST);
                        r_out_sec   <= w_row_sec ? SEC_W'(r_row) : '0;
                        r_out_val   <= r_val;
                        r_out_last  <= w_row_last;
                        if (w_row_last) begin
                            r_frames <= '0;
                            r_worst  <= '0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_row   <= r_row + ROW_W'(1);
                            r_state <= S_ROW;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Channel outputs.
    assign i_item.ready      = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_out_kind;
    assign o_res.section_res = r_out_sec;
    assign o_res.value_us    = r_out_val;
    assign o_res.last        = r_out_last;

endmodule : section_time_profiler_unit
`default_nettype wire

[rtl/stpu_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Section time profiler shared adder
// One wide add/subtract unit used for tick charging, the shift-and-add
// microsecond scaling and the restoring division steps.
// ----------------------------------------------------------------------------
module stpu_alu (
    input  logic [stpu_pkg::ACC_W-1:0] i_opa,
    input  logic [stpu_pkg::ACC_W-1:0] i_opb,
    input  logic                       i_sub,
    output logic [stpu_pkg::ACC_W-1:0] o_sum,
    output logic                       o_carry
);
    import stpu_pkg::*;

    logic [ACC_W-1:0] w_opb;
    logic [ACC_W:0]   w_full;

    // Subtraction is the addition of the complement plus one; the carry out
    // is then set when no borrow occurred.
    assign w_opb   = i_sub ? ~i_opb : i_opb;
    assign w_full  = {1'b0, i_opa} + {1'b0, w_opb} + {{ACC_W{1'b0}}, i_sub};
    assign o_sum   = w_full[ACC_W-1:0];
    assign o_carry = w_full[ACC_W];

endmodule : stpu_alu
`default_nettype wire

[rtl/stpu_tick_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Section time profiler tick store
// Per-section tick totals with one write port, one registered read port and
// a valid bit per entry so that a clear empties every entry together.
// ----------------------------------------------------------------------------
module stpu_tick_mem #(
    parameter int DEPTH = stpu_pkg::SECTIONS_DEF,
    parameter int AW    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clr,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [stpu_pkg::TICK_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [stpu_pkg::TICK_W-1:0] o_rdata
);
    import stpu_pkg::*;

    logic [TICK_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [TICK_W-1:0] r_rdata;

    // Valid bits: cleared by reset or a clear request, set by a write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // Storage array and registered read; an entry never written reads zero.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule : stpu_tick_mem
`default_nettype wire
